### rtl/cme_pkg.sv
package cme_pkg;

  localparam int NUM_TX     = 4;
  localparam int NUM_RX     = 4;
  localparam int MAX_TAPS   = 32;
  localparam int HIST_DEPTH = 256;
  localparam int LINKS      = NUM_TX * NUM_RX;
  localparam int TAP_DEPTH  = LINKS * MAX_TAPS;

  localparam int HIST_AW = $clog2(HIST_DEPTH);
  localparam int TAP_AW  = $clog2(TAP_DEPTH);
  localparam int TX_W    = $clog2(NUM_TX);
  localparam int RX_W    = $clog2(NUM_RX);
  localparam int TAP_W   = $clog2(MAX_TAPS);
  localparam int NA_W    = $clog2(NUM_TX + 1);
  localparam int NT_W    = $clog2(MAX_TAPS + 1);
  localparam int ACC_W   = 41;
  localparam int ROT_W   = 44;

  localparam logic CMD_TAP    = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [2:0] REG_ACTIVE_TX    = 3'd0;
  localparam logic [2:0] REG_TAP_COUNT    = 3'd1;
  localparam logic [2:0] REG_DELAY_OFFSET = 3'd2;
  localparam logic [2:0] REG_PATH_GAIN    = 3'd3;
  localparam logic [2:0] REG_NOISE_SCALE  = 3'd4;
  localparam logic [2:0] REG_DOPPLER_STEP = 3'd5;
  localparam logic [2:0] REG_RX_ANTENNA   = 3'd6;

  localparam logic signed [15:0] QUARTER_SIN [0:16] = '{
    16'sd0, 16'sd1606, 16'sd3196, 16'sd4756, 16'sd6270, 16'sd7723, 16'sd9102,
    16'sd10394, 16'sd11585, 16'sd12665, 16'sd13623, 16'sd14449, 16'sd15137,
    16'sd15679, 16'sd16069, 16'sd16305, 16'sd16384
  };

  typedef struct packed {
    logic               command;
    logic [3:0]         antenna;
    logic [4:0]         tap_index;
    logic signed [15:0] value_re;
    logic signed [15:0] value_im;
    logic signed [15:0] noise_re;
    logic signed [15:0] noise_im;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;
  } out_t;

  typedef struct packed {
    logic               clr;
    logic [HIST_AW-1:0] clr_addr;
    logic               accept;
    logic               mac_start;
    logic               mac_issue;
    logic [TX_W-1:0]    mac_tx;
    logic [TAP_W-1:0]   mac_tap;
    logic               rot_mul;
    logic               rot_sum;
    logic               scale;
    logic               load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic            last_ant;
    logic [NA_W-1:0] na;
    logic [NT_W-1:0] nt;
    logic            pipe_busy;
    logic            out_free;
  } dp_sts_t;

  function automatic logic signed [15:0] sin64(input logic [5:0] idx);
    logic signed [15:0] v;
    logic [4:0]         ri;
    ri = 5'd16 - {1'b0, idx[3:0]};
    v  = idx[4] ? QUARTER_SIN[ri] : QUARTER_SIN[{1'b0, idx[3:0]}];
    return idx[5] ? -v : v;
  endfunction

  function automatic logic signed [63:0] round_shift(input logic signed [63:0] x,
                                                     input logic [4:0] k);
    logic [63:0] mag;
    mag = x[63] ? (~x + 64'd1) : x;
    mag = (mag + (64'd1 << (k - 5'd1))) >> k;
    return x[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
    if (x > 64'sd32767) begin
      return 16'sh7fff;
    end else if (x < -64'sd32768) begin
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

endpackage

### rtl/mimo_channel_emulator.sv
// One receive antenna of a MIMO fading channel: tap loads and transmit samples enter on the
// in_ channel, and every sample of the last active tx antenna of an instant yields one
// received sample on the out_ channel. A tap load or any other sample is taken without
// stalling the input. A completing sample runs the single complex multiply-accumulate,
// which walks the history and tap memories one entry per cycle, then drains its pipeline
// and goes through the rotation, gain and rounding steps; while out_stall holds the
// previous result, the new one waits. After reset the history memory is cleared entry by
// entry, during which in_stall stays high; configuration writes are taken at any time.
module mimo_channel_emulator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cme_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cme_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [23:0]   cfg_wdata
);

  cme_pkg::ctl_cmd_t cmd;
  cme_pkg::dp_sts_t  sts;

  assign cfg_ready = 1'b1;

  cme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cme_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

### rtl/cme_ram.sv
module cme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/cme_ctrl.sv
module cme_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cme_pkg::dp_sts_t  sts,
  output cme_pkg::ctl_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MAC   = 8'b0000_0100,
    S_DRAIN = 8'b0000_1000,
    S_ROT1  = 8'b0001_0000,
    S_ROT2  = 8'b0010_0000,
    S_SCALE = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [cme_pkg::HIST_AW-1:0]  clr_r, clr_nxt;
  logic [cme_pkg::TX_W-1:0]     tx_r, tx_nxt;
  logic [cme_pkg::TAP_W-1:0]    l_r, l_nxt;
  logic                         tx_last, l_last;

  assign tx_last = int'(tx_r) == int'(sts.na) - 1;
  assign l_last  = int'(l_r) == int'(sts.nt) - 1;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    tx_nxt    = tx_r;
    l_nxt     = l_r;
    in_stall  = 1'b1;
    cmd       = '0;
    cmd.clr_addr = clr_r;
    cmd.mac_tx   = tx_r;
    cmd.mac_tap  = l_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (int'(clr_r) == cme_pkg::HIST_DEPTH - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && sts.last_ant) begin
          cmd.mac_start = 1'b1;
          tx_nxt        = '0;
          l_nxt         = '0;
          state_nxt     = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (l_last) begin
          l_nxt = '0;
          if (tx_last) begin
            state_nxt = S_DRAIN;
          end else begin
            tx_nxt = tx_r + 1'b1;
          end
        end else begin
          l_nxt = l_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_ROT1;
        end
      end
      S_ROT1: begin
        cmd.rot_mul = 1'b1;
        state_nxt   = S_ROT2;
      end
      S_ROT2: begin
        cmd.rot_sum = 1'b1;
        state_nxt   = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      tx_r    <= '0;
      l_r     <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      tx_r    <= tx_nxt;
      l_r     <= l_nxt;
    end
  end

endmodule

### rtl/cme_dp.sv
module cme_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  cme_pkg::in_t      in_data,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_wdata,
  input  cme_pkg::ctl_cmd_t cmd,
  output cme_pkg::dp_sts_t  sts,
  output logic              out_valid,
  output cme_pkg::out_t     out_data,
  input  logic              out_stall
);

  logic [2:0]  active_tx_r;
  logic [5:0]  tap_count_r;
  logic [5:0]  delay_offset_r;
  logic [15:0] path_gain_r;
  logic [15:0] noise_scale_r;
  logic [23:0] doppler_step_r;
  logic [1:0]  rx_antenna_r;

  logic [cme_pkg::NA_W-1:0] na;
  logic [cme_pkg::NT_W-1:0] nt;
  logic [cme_pkg::RX_W-1:0] rx;

  logic                        is_sample, sample_ok, tap_ok;
  logic                        hist_we;
  logic [cme_pkg::HIST_AW-1:0] hist_waddr, hist_raddr, inst;
  logic [31:0]                 hist_wdata, hist_rdata, tap_rdata;
  logic [cme_pkg::HIST_AW+3:0] wsum, rsum;
  logic [6:0]                  back;
  logic [cme_pkg::TAP_AW-1:0]  tap_waddr, tap_raddr;

  logic [cme_pkg::HIST_AW-1:0] wp_r;
  logic                        p1_v_r, p2_v_r;
  logic signed [31:0]          pp_rr_r, pp_ii_r, pp_ir_r, pp_ri_r;
  logic signed [cme_pkg::ACC_W-1:0] acc_re_r, acc_im_r;
  logic signed [15:0]          noise_re_r, noise_im_r;

  logic [23:0]        phase_r [cme_pkg::NUM_RX];
  logic [23:0]        ph_rnd;
  logic signed [15:0] sin_v, cos_v;
  logic signed [56:0] m_rc_r, m_is_r, m_rs_r, m_ic_r;
  logic signed [cme_pkg::ROT_W-1:0] rot_re_r, rot_im_r;
  logic signed [60:0] g_re_r, g_im_r;
  logic signed [32:0] n_re_r, n_im_r;
  logic signed [63:0] v_re, v_im;

  logic          out_valid_r;
  cme_pkg::out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_tx_r    <= 3'd1;
      tap_count_r    <= 6'd1;
      delay_offset_r <= '0;
      path_gain_r    <= 16'd4096;
      noise_scale_r  <= '0;
      doppler_step_r <= '0;
      rx_antenna_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cme_pkg::REG_ACTIVE_TX:    active_tx_r    <= cfg_wdata[2:0];
        cme_pkg::REG_TAP_COUNT:    tap_count_r    <= cfg_wdata[5:0];
        cme_pkg::REG_DELAY_OFFSET: delay_offset_r <= cfg_wdata[5:0];
        cme_pkg::REG_PATH_GAIN:    path_gain_r    <= cfg_wdata[15:0];
        cme_pkg::REG_NOISE_SCALE:  noise_scale_r  <= cfg_wdata[15:0];
        cme_pkg::REG_DOPPLER_STEP: doppler_step_r <= cfg_wdata;
        cme_pkg::REG_RX_ANTENNA:   rx_antenna_r   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (active_tx_r == '0) begin
      na = cme_pkg::NA_W'(1);
    end else if (int'(active_tx_r) > cme_pkg::NUM_TX) begin
      na = cme_pkg::NA_W'(cme_pkg::NUM_TX);
    end else begin
      na = cme_pkg::NA_W'(active_tx_r);
    end
    if (tap_count_r == '0) begin
      nt = cme_pkg::NT_W'(1);
    end else if (int'(tap_count_r) > cme_pkg::MAX_TAPS) begin
      nt = cme_pkg::NT_W'(cme_pkg::MAX_TAPS);
    end else begin
      nt = cme_pkg::NT_W'(tap_count_r);
    end
    if (int'(rx_antenna_r) >= cme_pkg::NUM_RX) begin
      rx = cme_pkg::RX_W'(cme_pkg::NUM_RX - 1);
    end else begin
      rx = cme_pkg::RX_W'(rx_antenna_r);
    end
  end

  assign is_sample = in_data.command == cme_pkg::CMD_SAMPLE;
  assign sample_ok = is_sample && (int'(in_data.antenna) < int'(na));
  assign tap_ok    = !is_sample && (int'(in_data.antenna) < cme_pkg::LINKS)
                     && (int'(in_data.tap_index) < cme_pkg::MAX_TAPS);

  assign sts.last_ant  = sample_ok && (int'(in_data.antenna) == int'(na) - 1);
  assign sts.na        = na;
  assign sts.nt        = nt;
  assign sts.pipe_busy = p1_v_r || p2_v_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign wsum       = (cme_pkg::HIST_AW+4)'(wp_r) * (cme_pkg::HIST_AW+4)'(na)
                      + (cme_pkg::HIST_AW+4)'(in_data.antenna);
  assign hist_we    = cmd.clr || (cmd.accept && sample_ok);
  assign hist_waddr = cmd.clr ? cmd.clr_addr : wsum[cme_pkg::HIST_AW-1:0];
  assign hist_wdata = cmd.clr ? 32'd0 : {in_data.value_im, in_data.value_re};

  assign back       = 7'(cmd.mac_tap) + 7'(delay_offset_r);
  assign inst       = wp_r - cme_pkg::HIST_AW'(back);
  assign rsum       = (cme_pkg::HIST_AW+4)'(inst) * (cme_pkg::HIST_AW+4)'(na)
                      + (cme_pkg::HIST_AW+4)'(cmd.mac_tx);
  assign hist_raddr = rsum[cme_pkg::HIST_AW-1:0];

  assign tap_waddr = cme_pkg::TAP_AW'(int'(in_data.antenna) * cme_pkg::MAX_TAPS
                                      + int'(in_data.tap_index));
  assign tap_raddr = cme_pkg::TAP_AW'((int'(rx) + int'(cmd.mac_tx) * cme_pkg::NUM_RX)
                                      * cme_pkg::MAX_TAPS + int'(cmd.mac_tap));

  cme_ram #(.WIDTH(32), .DEPTH(cme_pkg::HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  cme_ram #(.WIDTH(32), .DEPTH(cme_pkg::TAP_DEPTH)) u_taps (
    .clk   (clk),
    .we    (cmd.accept && tap_ok),
    .waddr (tap_waddr),
    .wdata ({in_data.value_im, in_data.value_re}),
    .raddr (tap_raddr),
    .rdata (tap_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= cmd.mac_issue;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    pp_rr_r <= $signed(hist_rdata[15:0]) * $signed(tap_rdata[15:0]);
    pp_ii_r <= $signed(hist_rdata[31:16]) * $signed(tap_rdata[31:16]);
    pp_ir_r <= $signed(hist_rdata[31:16]) * $signed(tap_rdata[15:0]);
    pp_ri_r <= $signed(hist_rdata[15:0]) * $signed(tap_rdata[31:16]);
    if (cmd.mac_start) begin
      acc_re_r   <= '0;
      acc_im_r   <= '0;
      noise_re_r <= in_data.noise_re;
      noise_im_r <= in_data.noise_im;
    end else if (p2_v_r) begin
      acc_re_r <= acc_re_r + cme_pkg::ACC_W'(pp_rr_r) - cme_pkg::ACC_W'(pp_ii_r);
      acc_im_r <= acc_im_r + cme_pkg::ACC_W'(pp_ir_r) + cme_pkg::ACC_W'(pp_ri_r);
    end
  end

  assign ph_rnd = phase_r[rx] + 24'h020000;
  assign sin_v  = cme_pkg::sin64(ph_rnd[23:18]);
  assign cos_v  = cme_pkg::sin64(ph_rnd[23:18] + 6'd16);

  always_ff @(posedge clk) begin
    if (cmd.rot_mul) begin
      m_rc_r <= acc_re_r * cos_v;
      m_is_r <= acc_im_r * sin_v;
      m_rs_r <= acc_re_r * sin_v;
      m_ic_r <= acc_im_r * cos_v;
    end
    if (cmd.rot_sum) begin
      if (doppler_step_r != '0) begin
        rot_re_r <= cme_pkg::ROT_W'(cme_pkg::round_shift(64'(m_rc_r) - 64'(m_is_r), 5'd14));
        rot_im_r <= cme_pkg::ROT_W'(cme_pkg::round_shift(64'(m_rs_r) + 64'(m_ic_r), 5'd14));
      end else begin
        rot_re_r <= cme_pkg::ROT_W'(acc_re_r);
        rot_im_r <= cme_pkg::ROT_W'(acc_im_r);
      end
    end
    if (cmd.scale) begin
      g_re_r <= rot_re_r * $signed({1'b0, path_gain_r});
      g_im_r <= rot_im_r * $signed({1'b0, path_gain_r});
      n_re_r <= noise_re_r * $signed({1'b0, noise_scale_r});
      n_im_r <= noise_im_r * $signed({1'b0, noise_scale_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cme_pkg::NUM_RX; i++) begin
        phase_r[i] <= '0;
      end
    end else if (cmd.rot_sum && doppler_step_r != '0) begin
      phase_r[rx] <= phase_r[rx] + doppler_step_r;
    end
  end

  assign v_re = 64'(g_re_r) + (64'(n_re_r) <<< 15);
  assign v_im = 64'(g_im_r) + (64'(n_im_r) <<< 15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      wp_r        <= '0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        wp_r        <= wp_r + 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.out_re <= cme_pkg::sat16(cme_pkg::round_shift(v_re, 5'd27));
      out_data_r.out_im <= cme_pkg::sat16(cme_pkg::round_shift(v_im, 5'd27));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/cme_checker.sv
module cme_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input cme_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input cme_pkg::out_t out_data,
  input logic          cfg_ready
);

  // A held result must keep its value until the transfer completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset starts the history clear, so no input is taken right after it.
  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A tap load finishes in its own cycle and leaves the block ready.
  a_tap_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.command == cme_pkg::CMD_TAP |=> !in_stall)
    else $error("tap load stalled the input");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind mimo_channel_emulator cme_checker u_cme_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);
